// ===== rtl/core/deadline_timer_queue_defines.svh =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_defines
// Assertion macros for the timer queue. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define DTQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DTQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared widths, codes, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int KIND_W      = 2;
    localparam int TID_W       = 16;

    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CANCEL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TICK   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD_INIT,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_WR_MOVING,
        OP_CAN_INIT,
        OP_CAN_READ,
        OP_CAN_MARK,
        OP_CAN_NEXT,
        OP_TICK_INIT,
        OP_ROOT_READ,
        OP_POP,
        OP_LOAD_LAST,
        OP_DN_READ,
        OP_DN_MOVE_L,
        OP_DN_MOVE_R,
        OP_PEND_SET,
        OP_PEND_SWAP,
        OP_EMIT_ADD,
        OP_EMIT_FULL,
        OP_EMIT_LAST
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FULL,
        S_UP_RD,
        S_UP_CMP,
        S_ADD_OUT,
        S_CAN_RD,
        S_CAN_CMP,
        S_TK_RD,
        S_TK_CHK,
        S_TK_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_TK_FIRE,
        S_TK_END
    } t_state;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic full;
        logic cnt_zero;
        logic hole_zero;
        logic up_before;
        logic idx_end;
        logic can_hit;
        logic due;
        logic l_end;
        logic dn_l;
        logic dn_r;
        logic popped_drop;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/dtq_in_if.sv =====
// ----------------------------------------------------------------------------
// dtq_in_if
// Request channel: add, cancel or tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtq_in_if;
    import dtq_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DELAY_W-1:0] delay;
    logic [TID_W-1:0]   target_id;

    modport source (output valid, output func, output delay, output target_id,
                    input ready);
    modport sink   (input valid, input func, input delay, input target_id,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtq_out_if.sv =====
// ----------------------------------------------------------------------------
// dtq_out_if
// Event channel: added, fired or full.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtq_out_if;
    import dtq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [TID_W-1:0]  timer_id;
    logic              last;

    modport source (output valid, output event_kind, output timer_id, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input timer_id, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath
// Heap memory, time and id counters, hole-based sift registers, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deadline_timer_queue_defines.svh"

module dtq_datapath #(
    parameter int DEPTH   = dtq_pkg::DEPTH_DEF,
    parameter int ID_BITS = dtq_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtq_pkg::t_cmd               i_cmd,
    output dtq_pkg::t_stat              o_stat,
    input  logic [dtq_pkg::FUNC_W-1:0]  i_func,
    input  logic [dtq_pkg::DELAY_W-1:0] i_delay,
    input  logic [dtq_pkg::TID_W-1:0]   i_target,
    dtq_out_if.source                   o_out
);
    import dtq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (ID_BITS > TID_W) ? ID_BITS : TID_W;

    typedef struct packed {
        logic [TIME_W-1:0]  dl;
        logic [ID_BITS-1:0] id;
        logic               drop;
    } t_entry;

    function automatic logic f_before(t_entry a, t_entry b);
        if (a.dl != b.dl) begin
            return a.dl < b.dl;
        end
        return a.id < b.id;
    endfunction

    t_entry mem [DEPTH];

    logic [FUNC_W-1:0]  r_func, n_func;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [TID_W-1:0]   r_target, n_target;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [ID_BITS-1:0] r_next_id, n_next_id;
    logic [ID_BITS-1:0] r_new_id, n_new_id;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_hole, n_hole;
    logic [CW-1:0]      r_idx, n_idx;
    t_entry             r_mov, n_mov;
    t_entry             r_rd_a, r_rd_b;
    logic [ID_BITS-1:0] r_pop_id, n_pop_id;
    logic               r_pop_drop, n_pop_drop;
    logic [ID_BITS-1:0] r_pend_id, n_pend_id;
    logic               r_pend_valid, n_pend_valid;
    logic               r_out_valid, n_out_valid;
    logic [KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [TID_W-1:0]   r_out_id, n_out_id;
    logic               r_out_last, n_out_last;

    logic               we;
    logic [AW-1:0]      wa, ra, rb;
    t_entry             wd, marked;
    logic [CW-1:0]      parent, cnt_m1;
    logic [CW:0]        lw, rw;
    logic               bl, br;
    t_entry             cand;
    logic [IW-1:0]      new_ext, pend_ext;
    logic [ID_BITS-1:0] id_inc;

    assign parent   = (r_hole - CW'(1)) >> 1;
    assign cnt_m1   = r_count - CW'(1);
    assign lw       = {r_hole, 1'b1};
    assign rw       = lw + (CW + 1)'(1);
    assign new_ext  = IW'(r_new_id);
    assign pend_ext = IW'(r_pend_id);
    assign id_inc   = r_next_id + ID_BITS'(1);
    assign bl       = f_before(r_rd_a, r_mov);
    assign cand     = bl ? r_rd_a : r_mov;
    assign br       = (rw < {1'b0, r_count}) && f_before(r_rd_b, cand);

    always_comb begin
        marked      = r_rd_a;
        marked.drop = 1'b1;
    end

    always_comb begin
        o_stat.func        = r_func;
        o_stat.full        = r_count >= CW'(DEPTH);
        o_stat.cnt_zero    = r_count == '0;
        o_stat.hole_zero   = r_hole == '0;
        o_stat.up_before   = f_before(r_mov, r_rd_a);
        o_stat.idx_end     = r_idx >= r_count;
        o_stat.can_hit     = !r_rd_a.drop && (IW'(r_rd_a.id) == IW'(r_target));
        o_stat.due         = r_rd_a.dl <= r_time;
        o_stat.l_end       = lw >= {1'b0, r_count};
        o_stat.dn_l        = bl && !br;
        o_stat.dn_r        = br;
        o_stat.popped_drop = r_pop_drop;
        o_stat.pend_valid  = r_pend_valid;
        o_stat.out_free    = !r_out_valid || o_out.ready;
    end

    always_comb begin
        n_func       = r_func;
        n_delay      = r_delay;
        n_target     = r_target;
        n_time       = r_time;
        n_next_id    = r_next_id;
        n_new_id     = r_new_id;
        n_count      = r_count;
        n_hole       = r_hole;
        n_idx        = r_idx;
        n_mov        = r_mov;
        n_pop_id     = r_pop_id;
        n_pop_drop   = r_pop_drop;
        n_pend_id    = r_pend_id;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        we           = 1'b0;
        wa           = r_hole[AW-1:0];
        wd           = r_mov;
        ra           = '0;
        rb           = '0;

        if (i_cmd.load) begin
            n_func   = i_func;
            n_delay  = i_delay;
            n_target = i_target;
        end

        case (i_cmd.op)
            OP_ADD_INIT: begin
                n_mov.dl   = r_time + TIME_W'(r_delay);
                n_mov.id   = r_next_id;
                n_mov.drop = 1'b0;
                n_new_id   = r_next_id;
                n_next_id  = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                n_hole     = r_count;
                n_count    = r_count + CW'(1);
            end
            OP_UP_READ: ra = parent[AW-1:0];
            OP_UP_MOVE: begin
                we     = 1'b1;
                wd     = r_rd_a;
                n_hole = parent;
            end
            OP_WR_MOVING: we = 1'b1;
            OP_CAN_INIT:  n_idx = '0;
            OP_CAN_READ:  ra = r_idx[AW-1:0];
            OP_CAN_MARK: begin
                we = 1'b1;
                wa = r_idx[AW-1:0];
                wd = marked;
            end
            OP_CAN_NEXT:  n_idx = r_idx + CW'(1);
            OP_TICK_INIT: n_time = r_time + TIME_W'(1);
            OP_ROOT_READ: ra = '0;
            OP_POP: begin
                n_pop_id   = r_rd_a.id;
                n_pop_drop = r_rd_a.drop;
                n_count    = cnt_m1;
                n_hole     = '0;
                ra         = cnt_m1[AW-1:0];
            end
            OP_LOAD_LAST: n_mov = r_rd_a;
            OP_DN_READ: begin
                ra = lw[AW-1:0];
                rb = rw[AW-1:0];
            end
            OP_DN_MOVE_L: begin
                we     = 1'b1;
                wd     = r_rd_a;
                n_hole = lw[CW-1:0];
            end
            OP_DN_MOVE_R: begin
                we     = 1'b1;
                wd     = r_rd_b;
                n_hole = rw[CW-1:0];
            end
            OP_PEND_SET: begin
                n_pend_id    = r_pop_id;
                n_pend_valid = 1'b1;
            end
            OP_PEND_SWAP: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_FIRED;
                n_out_id    = pend_ext[TID_W-1:0];
                n_out_last  = 1'b0;
                n_pend_id   = r_pop_id;
            end
            OP_EMIT_ADD: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_ADDED;
                n_out_id    = new_ext[TID_W-1:0];
                n_out_last  = 1'b1;
            end
            OP_EMIT_FULL: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_FULL;
                n_out_id    = '0;
                n_out_last  = 1'b1;
            end
            OP_EMIT_LAST: begin
                n_out_valid  = 1'b1;
                n_out_kind   = KIND_FIRED;
                n_out_id     = pend_ext[TID_W-1:0];
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_a <= mem[ra];
        r_rd_b <= mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_next_id    <= ID_BITS'(1);
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_time       <= n_time;
            r_next_id    <= n_next_id;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_delay    <= n_delay;
        r_target   <= n_target;
        r_new_id   <= n_new_id;
        r_hole     <= n_hole;
        r_idx      <= n_idx;
        r_mov      <= n_mov;
        r_pop_id   <= n_pop_id;
        r_pop_drop <= n_pop_drop;
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;
    assign o_out.timer_id   = r_out_id;
    assign o_out.last       = r_out_last;

    `DTQ_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count above depth")
    `DTQ_ASSERT(a_add_grows, i_clk, i_rst_n, (i_cmd.op == OP_ADD_INIT) |=> (r_count == $past(r_count) + CW'(1)), "add did not grow the heap")
    `DTQ_ASSERT(a_hole_range, i_clk, i_rst_n, (i_cmd.op == OP_DN_READ) |-> (r_hole < r_count), "sift hole outside heap")
    `DTQ_ASSERT(a_emit_free, i_clk, i_rst_n, (i_cmd.op == OP_EMIT_ADD || i_cmd.op == OP_EMIT_FULL || i_cmd.op == OP_EMIT_LAST || i_cmd.op == OP_PEND_SWAP) |-> (!r_out_valid || o_out.ready), "event overwrote a pending output")

endmodule

`default_nettype wire

// ===== rtl/core/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for add (sift up), cancel (scan) and tick (pop and sift down).
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dtq_pkg::t_stat i_stat,
    output dtq_pkg::t_cmd  o_cmd
);
    import dtq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_ADD: begin
                        if (i_stat.full) begin
                            n_state = S_FULL;
                        end else begin
                            o_cmd.op = OP_ADD_INIT;
                            n_state  = S_UP_RD;
                        end
                    end
                    FN_CANCEL: begin
                        o_cmd.op = OP_CAN_INIT;
                        n_state  = S_CAN_RD;
                    end
                    FN_TICK: begin
                        o_cmd.op = OP_TICK_INIT;
                        n_state  = S_TK_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FULL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_FULL;
                    n_state  = S_IDLE;
                end
            end
            S_UP_RD: begin
                if (i_stat.hole_zero) begin
                    o_cmd.op = OP_WR_MOVING;
                    n_state  = S_ADD_OUT;
                end else begin
                    o_cmd.op = OP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_before) begin
                    o_cmd.op = OP_UP_MOVE;
                    n_state  = S_UP_RD;
                end else begin
                    o_cmd.op = OP_WR_MOVING;
                    n_state  = S_ADD_OUT;
                end
            end
            S_ADD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_ADD;
                    n_state  = S_IDLE;
                end
            end
            S_CAN_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_CAN_READ;
                    n_state  = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (i_stat.can_hit) begin
                    o_cmd.op = OP_CAN_MARK;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_CAN_NEXT;
                    n_state  = S_CAN_RD;
                end
            end
            S_TK_RD: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_TK_END;
                end else begin
                    o_cmd.op = OP_ROOT_READ;
                    n_state  = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (i_stat.due) begin
                    o_cmd.op = OP_POP;
                    n_state  = S_TK_LAST;
                end else begin
                    n_state = S_TK_END;
                end
            end
            S_TK_LAST: begin
                // last entry moves into the root hole and sinks
                if (i_stat.cnt_zero) begin
                    n_state = S_TK_FIRE;
                end else begin
                    o_cmd.op = OP_LOAD_LAST;
                    n_state  = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (i_stat.l_end) begin
                    o_cmd.op = OP_WR_MOVING;
                    n_state  = S_TK_FIRE;
                end else begin
                    o_cmd.op = OP_DN_READ;
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_r) begin
                    o_cmd.op = OP_DN_MOVE_R;
                    n_state  = S_DN_RD;
                end else if (i_stat.dn_l) begin
                    o_cmd.op = OP_DN_MOVE_L;
                    n_state  = S_DN_RD;
                end else begin
                    o_cmd.op = OP_WR_MOVING;
                    n_state  = S_TK_FIRE;
                end
            end
            S_TK_FIRE: begin
                // one fired id is held back until we know whether it is the last
                if (i_stat.popped_drop) begin
                    n_state = S_TK_RD;
                end else if (!i_stat.pend_valid) begin
                    o_cmd.op = OP_PEND_SET;
                    n_state  = S_TK_RD;
                end else if (i_stat.out_free) begin
                    o_cmd.op = OP_PEND_SWAP;
                    n_state  = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_LAST;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Millisecond timer queue on a min-heap of (deadline, id) in block memory.
//
//   channel | dir | payload
//   i_in    | in  | func, delay, target_id
//   o_out   | out | event_kind, timer_id, last
//
// One request at a time. Add sifts the new entry up the heap, then waits for
// the output handshake; when full it emits a full event. Cancel scans the
// entries in order. Tick reads the root and pops each due entry, moving the
// last entry into the root hole and sinking it; the heap memory has a single
// write port.
// Reset clears count, time and the valid flags and sets the id counter to 1;
// heap contents need no clearing. A stalled output holds the sequencer at
// its next event; input is taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue #(
    parameter int DEPTH   = dtq_pkg::DEPTH_DEF,
    parameter int ID_BITS = dtq_pkg::ID_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtq_in_if.sink    i_in,
    dtq_out_if.source o_out
);
    import dtq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dtq_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_func   (i_in.func),
        .i_delay  (i_in.delay),
        .i_target (i_in.target_id),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer queue: directed table, then random
// add/cancel/tick/unused traffic checked against a behavioral min-heap predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dtq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  id;
        logic              last;
    } t_event;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [DELAY_W-1:0] delay;
        logic [TID_W-1:0]   target;
        logic               chk;
        t_event             ev;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dtq_in_if  req_if ();
    dtq_out_if evt_if ();

    deadline_timer_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (evt_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [47:0] hp_dl [QDEPTH];
    logic [15:0] hp_id [QDEPTH];
    logic        hp_drop [QDEPTH];
    int          hp_cnt;
    logic [15:0] id_next;
    logic [47:0] now_ms;

    t_event expected_events[$];
    int     errors;
    int     n_events;
    int     n_fired;
    int     n_full;
    longint cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    function automatic bit hp_less(int a, int b);
        if (hp_dl[a] != hp_dl[b]) return hp_dl[a] < hp_dl[b];
        return hp_id[a] < hp_id[b];
    endfunction

    function automatic void hp_swap(int a, int b);
        logic [47:0] d;
        logic [15:0] i;
        logic        x;
        d = hp_dl[a]; i = hp_id[a]; x = hp_drop[a];
        hp_dl[a] = hp_dl[b]; hp_id[a] = hp_id[b]; hp_drop[a] = hp_drop[b];
        hp_dl[b] = d; hp_id[b] = i; hp_drop[b] = x;
    endfunction

    function automatic void predict_timer_events(logic [FUNC_W-1:0] func,
                                                 logic [DELAY_W-1:0] delay,
                                                 logic [TID_W-1:0] target);
        int     pos;
        int     par;
        int     best;
        int     n;
        t_event ev;
        if (func == FN_ADD) begin
            if (hp_cnt >= QDEPTH) begin
                ev.kind = KIND_FULL; ev.id = '0; ev.last = 1'b1;
                expected_events.push_back(ev);
                return;
            end
            pos = hp_cnt;
            hp_dl[pos] = now_ms + {16'd0, delay};
            hp_id[pos] = id_next;
            hp_drop[pos] = 1'b0;
            hp_cnt++;
            ev.kind = KIND_ADDED; ev.id = id_next; ev.last = 1'b1;
            expected_events.push_back(ev);
            id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
            while (pos > 0) begin
                par = (pos - 1) / 2;
                if (!hp_less(pos, par)) break;
                hp_swap(pos, par);
                pos = par;
            end
        end else if (func == FN_CANCEL) begin
            for (int i = 0; i < hp_cnt; i++)
                if (!hp_drop[i] && hp_id[i] == target) begin
                    hp_drop[i] = 1'b1;
                    break;
                end
        end else if (func == FN_TICK) begin
            n = 0;
            now_ms = now_ms + 48'd1;
            while (hp_cnt > 0 && hp_dl[0] <= now_ms) begin
                ev.kind = KIND_FIRED; ev.id = hp_id[0]; ev.last = 1'b0;
                hp_cnt--;
                if (!hp_drop[0]) begin
                    expected_events.push_back(ev);
                    n++;
                end
                if (hp_cnt > 0) begin
                    hp_swap(0, hp_cnt);
                    pos = 0;
                    forever begin
                        best = pos;
                        if (2*pos+1 < hp_cnt && hp_less(2*pos+1, best)) best = 2*pos+1;
                        if (2*pos+2 < hp_cnt && hp_less(2*pos+2, best)) best = 2*pos+2;
                        if (best == pos) break;
                        hp_swap(pos, best);
                        pos = best;
                    end
                end
            end
            if (n > 0) expected_events[$].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR t=%0t %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // receiver: random stall and compare against oldest expectation
    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                n_events++;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event id", evt_if.timer_id, 0);
                end else begin
                    want = expected_events.pop_front();
                    if (evt_if.event_kind != want.kind)
                        report_mismatch("event_kind", evt_if.event_kind, want.kind);
                    if (evt_if.timer_id != want.id)
                        report_mismatch("timer_id", evt_if.timer_id, want.id);
                    if (evt_if.last != want.last)
                        report_mismatch("last", evt_if.last, want.last);
                    if (want.kind == KIND_FIRED) n_fired++;
                    if (want.kind == KIND_FULL) n_full++;
                end
            end
            evt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("deadline_timer_queue: mismatch");
            $finish;
        end
    end

    // one transaction; predictor runs at acceptance, valid stays up until
    // the next idle cycle or the next transaction replaces it
    task automatic send_request(logic [FUNC_W-1:0] func, logic [DELAY_W-1:0] delay,
                                logic [TID_W-1:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= func;
        req_if.delay     <= delay;
        req_if.target_id <= target;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_timer_events(func, delay, target);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [DELAY_W-1:0] rand_delay();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(6);
        if (r < 90) return $urandom_range(40);
        return $urandom;
    endfunction

    task automatic random_phase(int n_items);
        int r;
        logic [TID_W-1:0] tgt;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_request(FN_ADD, rand_delay(), TID_W'($urandom));
            end else if (r < 60) begin
                tgt = (hp_cnt > 0 && $urandom_range(3) != 0)
                      ? hp_id[$urandom_range(hp_cnt - 1)] : 16'($urandom);
                send_request(FN_CANCEL, $urandom, tgt);
            end else if (r < 97) begin
                send_request(FN_TICK, $urandom, TID_W'($urandom));
            end else begin
                send_request(FN_UNUSED, $urandom, TID_W'($urandom));
            end
        end
    endtask

    t_row table_rows[$];

    function automatic void add_row(logic [FUNC_W-1:0] f, logic [DELAY_W-1:0] d,
                                    logic [TID_W-1:0] t, logic c, t_event e);
        t_row row;
        row.func = f; row.delay = d; row.target = t; row.chk = c; row.ev = e;
        table_rows.push_back(row);
    endfunction

    initial begin
        t_event none;
        none = '0;
        errors = 0; n_events = 0; n_fired = 0; n_full = 0; cycles = 0;
        hp_cnt = 0; id_next = 16'd1; now_ms = '0;
        send_idle_pct = 13; recv_idle_pct = 63;
        req_if.valid = 1'b0; req_if.func = FN_TICK;
        req_if.delay = '0; req_if.target_id = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero delay, max delay, equal deadlines, cancel, unused selector, full
        add_row(FN_TICK, '0, '0, 1'b0, none);                        // nothing due
        add_row(FN_ADD, 32'd0, '0, 1'b1, '{KIND_ADDED, 16'd1, 1'b1});
        add_row(FN_ADD, 32'hFFFF_FFFF, '0, 1'b1, '{KIND_ADDED, 16'd2, 1'b1});
        add_row(FN_ADD, 32'd2, '0, 1'b1, '{KIND_ADDED, 16'd3, 1'b1});
        add_row(FN_ADD, 32'd2, '0, 1'b1, '{KIND_ADDED, 16'd4, 1'b1});
        add_row(FN_ADD, 32'd2, '0, 1'b1, '{KIND_ADDED, 16'd5, 1'b1});
        add_row(FN_CANCEL, '1, 16'd4, 1'b0, none);
        add_row(FN_CANCEL, '0, 16'd4, 1'b0, none);                   // already dropped
        add_row(FN_CANCEL, '0, 16'hFFFF, 1'b0, none);                // unknown id
        add_row(FN_CANCEL, '0, 16'd0, 1'b0, none);
        add_row(FN_UNUSED, '1, '1, 1'b0, none);                      // unused selector
        add_row(FN_TICK, '0, '0, 1'b0, none);
        add_row(FN_TICK, '0, '0, 1'b0, none);
        // one long timer remains; fifteen more fill the heap
        for (int i = 0; i < 15; i++)
            add_row(FN_ADD, DELAY_W'(10 + i), '0, 1'b0, none);
        add_row(FN_ADD, 32'd5, '0, 1'b1, '{KIND_FULL, 16'd0, 1'b1});

        foreach (table_rows[i]) begin
            send_request(table_rows[i].func, table_rows[i].delay, table_rows[i].target);
            if (table_rows[i].chk) begin
                if (expected_events.size() == 0)
                    report_mismatch("no event for table row", i, table_rows[i].ev);
                else if (expected_events[$] != table_rows[i].ev)
                    report_mismatch("predictor vs table", expected_events[$],
                                    table_rows[i].ev);
            end
        end
        wait_drained();

        // drain the short directed timers by ticking past them; the long one stays
        for (int i = 0; i < 30; i++) send_request(FN_TICK, '0, '0);

        random_phase(14);
        wait_drained();                        // sender holds off until drained
        send_idle_pct = 63; recv_idle_pct = 13;
        random_phase(14);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(14);
        wait_drained();

        $display("ran directed table plus ~42 random requests: %0d events, %0d fired, %0d full",
                 n_events, n_fired, n_full);
        if (errors == 0) begin
            $display("deadline_timer_queue: match");
        end else begin
            $display("deadline_timer_queue: mismatch");
        end
        $finish;
    end
endmodule
